// ===== rtl/core/hrq_pkg.sv =====
// Shared types, widths and codes for the HRRN ready queue.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package hrq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int OP_W     = 2;
    localparam int ID_W     = 8;
    localparam int TIME_W   = 16;
    localparam int PRIO_W   = 21;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    // Q13.8 priority, tick divider sizes
    localparam int FRAC_W   = 8;
    localparam int PRIO_ONE = 1 << FRAC_W;
    localparam int NUM_W    = TIME_W + FRAC_W;
    localparam int DEN_W    = TIME_W + 4;
    localparam int ITER_W   = $clog2(NUM_W + 1);
    localparam logic [PRIO_W-1:0] PRIO_MAX = '1;

    // stream packing
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 16;
    localparam int EST_LSB    = ID_W;
    localparam int WAIT_LSB   = EST_LSB + TIME_W;
    localparam int PRIO_LSB   = WAIT_LSB + TIME_W;

    localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK    = 2'd2;
    localparam logic [OP_W-1:0] OP_PICK    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]   job;
        logic [TIME_W-1:0] wait_time;
        logic [TIME_W-1:0] est_time;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic [IDX_W-1:0] raddr;
    } t_ram_cmd;

    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] wait_time;
        logic [TIME_W-1:0] est_time;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [PRIO_W-1:0] prio;
    } t_div_rsp;

endpackage

// ===== rtl/core/hrq_ram.sv =====
// Entry table: one write port, one registered read port.
// Depends on hrq_pkg.
`timescale 1ns / 1ps

module hrq_ram (
    input  logic              i_clk,
    input  hrq_pkg::t_ram_cmd i_cmd,
    output hrq_pkg::t_entry   o_rdata
);

    hrq_pkg::t_entry r_mem [hrq_pkg::DEPTH];
    hrq_pkg::t_entry r_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.waddr] <= i_cmd.wdata;
        end
        r_q <= r_mem[i_cmd.raddr];
    end

    assign o_rdata = r_q;

endmodule

// ===== rtl/core/hrq_div.sv =====
// Serial restoring divider for the tick priority:
// prio = floor(wait * 256 / (10 * est)) + 256, saturated. Depends on hrq_pkg.
`timescale 1ns / 1ps

module hrq_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hrq_pkg::t_div_req i_req,
    output hrq_pkg::t_div_rsp o_rsp
);

    localparam logic [hrq_pkg::NUM_W-1:0] SAT_QUO =
        hrq_pkg::NUM_W'((1 << hrq_pkg::PRIO_W) - hrq_pkg::PRIO_ONE);

    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [hrq_pkg::ITER_W-1:0]    r_cnt, n_cnt;
    logic [hrq_pkg::NUM_W-1:0]     r_num, n_num;
    logic [hrq_pkg::NUM_W-1:0]     r_quo, n_quo;
    logic [hrq_pkg::DEN_W-1:0]     r_rem, n_rem;
    logic [hrq_pkg::DEN_W-1:0]     r_den, n_den;
    logic                          r_zero, n_zero;
    logic [hrq_pkg::PRIO_W-1:0]    r_prio, n_prio;
    logic [hrq_pkg::DEN_W:0]       trial;
    logic [hrq_pkg::DEN_W-1:0]     est_ext;

    assign est_ext = hrq_pkg::DEN_W'(i_req.est_time);
    assign trial   = {r_rem, r_num[hrq_pkg::NUM_W-1]};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_zero = r_zero;
        n_prio = r_prio;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = hrq_pkg::ITER_W'(hrq_pkg::NUM_W);
            n_num  = {i_req.wait_time, hrq_pkg::FRAC_W'(0)};
            n_quo  = '0;
            n_rem  = '0;
            // 10 * est as 8 * est + 2 * est
            n_den  = (est_ext << 3) + (est_ext << 1);
            n_zero = (i_req.est_time == '0);
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                n_cnt = r_cnt - 1'b1;
                n_num = r_num << 1;
                if (trial >= {1'b0, r_den}) begin
                    n_rem = hrq_pkg::DEN_W'(trial - {1'b0, r_den});
                    n_quo = {r_quo[hrq_pkg::NUM_W-2:0], 1'b1};
                end else begin
                    n_rem = trial[hrq_pkg::DEN_W-1:0];
                    n_quo = {r_quo[hrq_pkg::NUM_W-2:0], 1'b0};
                end
            end else begin
                n_busy = 1'b0;
                n_done = 1'b1;
                if (r_zero || (r_quo >= SAT_QUO)) begin
                    n_prio = hrq_pkg::PRIO_MAX;
                end else begin
                    n_prio = r_quo[hrq_pkg::PRIO_W-1:0]
                           + hrq_pkg::PRIO_W'(hrq_pkg::PRIO_ONE);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_num  <= n_num;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_zero <= n_zero;
        r_prio <= n_prio;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.prio = r_prio;

endmodule

// ===== rtl/core/hrrn_ready_queue_core.sv =====
// Top level of the HRRN ready queue: operation sequencer and output register.
// Depends on hrq_pkg, hrq_ram and hrq_div.
`timescale 1ns / 1ps

// Ready table for a highest-response-ratio-next scheduler, DEPTH entries.
// Input channel (s_axis): one operation per transfer; tuser carries the op
// (enqueue, dequeue, tick, pick), tdata the job id, estimate, waiting time
// and Q13.8 priority. Output channel (m_axis): one result per operation with
// the current pick, pick valid flag, job count and status.
// Operations run one at a time. Dequeue, tick and enqueue make a pass over
// the table memory (one read per cycle; a tick pass ends at its hit); enqueue
// then writes the tail slot. Every op ends with a pick pass over the jobs
// left and a load of the output register. Enqueue into an empty table goes
// straight to the tail slot; enqueue into a full table is dropped, and
// dequeue or tick on an empty table skip the pass, going straight to the pick
// pass. A tick hit waits for the serial divider between lookup and pick pass.
// The single read port of the table sets the length of each pass.
// The result sits in an output register; the next operation is accepted
// while it waits. If the receiver stalls, a finished result holds the
// sequencer until the register frees, then tready returns.
// Reset empties the table (job count zero); the table memory is not cleared,
// since only entries below the count are ever read.

module hrrn_ready_queue_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [7:0] job_id, [23:8] est_time, [39:24] wait_time,
    // [60:40] priority_req, [63:61] zero
    input  logic [hrq_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // [1:0] op
    input  logic [hrq_pkg::OP_W-1:0]         i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [7:0] pick_id, [8] pick_valid, [13:9] job_count, [15:14] status
    output logic [hrq_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;  // op pass over the table
    localparam logic [2:0] S_TAIL = 3'd2;  // enqueue: write the last slot
    localparam logic [2:0] S_DIV  = 3'd3;  // tick: wait for the divider
    localparam logic [2:0] S_PICK = 3'd4;  // max search pass
    localparam logic [2:0] S_OUT  = 3'd5;  // load output register

    logic [2:0]                     r_state, n_state;
    logic [hrq_pkg::OP_W-1:0]       r_op, n_op;
    logic [hrq_pkg::ID_W-1:0]       r_id, n_id;
    hrq_pkg::t_entry                r_new, n_new;
    hrq_pkg::t_entry                r_carry, n_carry;
    logic [hrq_pkg::CNT_W-1:0]      r_count, n_count;
    logic [hrq_pkg::CNT_W-1:0]      r_rd_cnt, n_rd_cnt;
    logic                           r_rv, n_rv;
    logic [hrq_pkg::IDX_W-1:0]      r_ri, n_ri;
    logic                           r_found, n_found;
    logic [hrq_pkg::IDX_W-1:0]      r_hit, n_hit;
    logic [hrq_pkg::STATUS_W-1:0]   r_status, n_status;
    logic [hrq_pkg::PRIO_W-1:0]     r_best_prio, n_best_prio;
    logic [hrq_pkg::ID_W-1:0]       r_best_id, n_best_id;
    logic                           r_m_valid, n_m_valid;
    logic [hrq_pkg::OUT_DATA_W-1:0] r_m_data, n_m_data;

    hrq_pkg::t_ram_cmd ram_cmd;
    hrq_pkg::t_entry   q;
    hrq_pkg::t_div_req div_req;
    hrq_pkg::t_div_rsp div_rsp;

    logic s_accept;
    logic rd_go;
    logic scan_last;
    logic hit_now;
    logic pick_go;
    logic [hrq_pkg::TIME_W-1:0] q_wait_inc;

    hrq_ram u_ram (
        .i_clk   (i_clk),
        .i_cmd   (ram_cmd),
        .o_rdata (q)
    );

    hrq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    // one table read per cycle during a pass; read data is registered and returns in the next cycle
    assign rd_go     = ((r_state == S_SCAN) || (r_state == S_PICK)) && (r_rd_cnt < r_count);
    assign scan_last = r_rv && (hrq_pkg::CNT_W'(r_ri) == r_count - 1'b1);
    assign hit_now   = r_rv && !r_found && (q.job == r_id);
    // waiting time saturates at all ones
    assign q_wait_inc = (q.wait_time == '1) ? q.wait_time : q.wait_time + 1'b1;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_id        = r_id;
        n_new       = r_new;
        n_carry     = r_carry;
        n_count     = r_count;
        n_rd_cnt    = r_rd_cnt;
        n_rv        = rd_go;
        n_ri        = r_rd_cnt[hrq_pkg::IDX_W-1:0];
        n_found     = r_found;
        n_hit       = r_hit;
        n_status    = r_status;
        n_best_prio = r_best_prio;
        n_best_id   = r_best_id;
        n_m_valid   = r_m_valid && !i_m_axis_tready;
        n_m_data    = r_m_data;
        pick_go     = 1'b0;

        ram_cmd       = '0;
        ram_cmd.raddr = r_rd_cnt[hrq_pkg::IDX_W-1:0];
        div_req       = '0;

        if (rd_go) begin
            n_rd_cnt = r_rd_cnt + 1'b1;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_op              = i_s_axis_tuser;
                    n_id              = i_s_axis_tdata[hrq_pkg::ID_W-1:0];
                    n_new.job         = i_s_axis_tdata[hrq_pkg::ID_W-1:0];
                    n_new.est_time    = i_s_axis_tdata[hrq_pkg::EST_LSB +: hrq_pkg::TIME_W];
                    n_new.wait_time   = i_s_axis_tdata[hrq_pkg::WAIT_LSB +: hrq_pkg::TIME_W];
                    n_new.prio        = i_s_axis_tdata[hrq_pkg::PRIO_LSB +: hrq_pkg::PRIO_W];
                    n_found           = 1'b0;
                    n_status          = hrq_pkg::ST_OK;
                    n_rd_cnt          = '0;
                    n_rv              = 1'b0;
                    unique case (i_s_axis_tuser)
                        hrq_pkg::OP_ENQUEUE: begin
                            if (r_count == hrq_pkg::CNT_W'(hrq_pkg::DEPTH)) begin
                                n_status = hrq_pkg::ST_FULL;
                                pick_go  = 1'b1;
                            end else if (r_count == '0) begin
                                n_state = S_TAIL;   // empty table: straight to slot 0
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        hrq_pkg::OP_DEQUEUE, hrq_pkg::OP_TICK: begin
                            if (r_count == '0) begin
                                n_status = hrq_pkg::ST_NOT_FOUND;
                                pick_go  = 1'b1;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        hrq_pkg::OP_PICK: begin
                            pick_go = 1'b1;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (r_rv) begin
                    unique case (r_op)
                        hrq_pkg::OP_ENQUEUE: begin
                            // insert before the first lower entry, then ripple
                            // the displaced entries up by one slot
                            if (!r_found) begin
                                if (r_new.prio > q.prio) begin
                                    ram_cmd.we    = 1'b1;
                                    ram_cmd.waddr = r_ri;
                                    ram_cmd.wdata = r_new;
                                    n_found       = 1'b1;
                                    n_carry       = q;
                                end
                            end else begin
                                ram_cmd.we    = 1'b1;
                                ram_cmd.waddr = r_ri;
                                ram_cmd.wdata = r_carry;
                                n_carry       = q;
                            end
                            if (scan_last) begin
                                n_state = S_TAIL;
                            end
                        end
                        hrq_pkg::OP_DEQUEUE: begin
                            // after the first match, every entry moves down one
                            if (hit_now) begin
                                n_found = 1'b1;
                            end else if (r_found) begin
                                ram_cmd.we    = 1'b1;
                                ram_cmd.waddr = r_ri - 1'b1;
                                ram_cmd.wdata = q;
                            end
                            if (scan_last) begin
                                if (r_found || hit_now) begin
                                    n_count = r_count - 1'b1;
                                end else begin
                                    n_status = hrq_pkg::ST_NOT_FOUND;
                                end
                                pick_go = 1'b1;
                            end
                        end
                        hrq_pkg::OP_TICK: begin
                            if (hit_now) begin
                                n_hit             = r_ri;
                                n_carry           = q;
                                n_carry.wait_time = q_wait_inc;
                                div_req.start     = 1'b1;
                                div_req.wait_time = q_wait_inc;
                                div_req.est_time  = q.est_time;
                                n_state           = S_DIV;
                            end else if (scan_last) begin
                                n_status = hrq_pkg::ST_NOT_FOUND;
                                pick_go  = 1'b1;
                            end
                        end
                        hrq_pkg::OP_PICK: begin
                            pick_go = 1'b1;
                        end
                    endcase
                end
            end

            S_TAIL: begin
                ram_cmd.we    = 1'b1;
                ram_cmd.waddr = r_count[hrq_pkg::IDX_W-1:0];
                ram_cmd.wdata = r_found ? r_carry : r_new;
                n_count       = r_count + 1'b1;
                pick_go       = 1'b1;
            end

            S_DIV: begin
                if (div_rsp.done) begin
                    ram_cmd.we         = 1'b1;
                    ram_cmd.waddr      = r_hit;
                    ram_cmd.wdata      = r_carry;
                    ram_cmd.wdata.prio = div_rsp.prio;
                    pick_go            = 1'b1;
                end
            end

            S_PICK: begin
                if (r_count == '0) begin
                    n_state = S_OUT;
                end else if (r_rv) begin
                    // strict compare keeps the first entry on ties
                    if ((r_ri == '0) || (q.prio > r_best_prio)) begin
                        n_best_prio = q.prio;
                        n_best_id   = q.job;
                    end
                    if (scan_last) begin
                        n_state = S_OUT;
                    end
                end
            end

            S_OUT: begin
                if (!r_m_valid || i_m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {r_status,
                                 hrq_pkg::COUNT_W'(r_count),
                                 (r_count != '0),
                                 r_best_id};
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (pick_go) begin
            n_state     = S_PICK;
            n_rd_cnt    = '0;
            n_rv        = 1'b0;
            n_best_id   = '0;
            n_best_prio = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_rd_cnt  <= '0;
            r_rv      <= 1'b0;
            r_found   <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rd_cnt  <= n_rd_cnt;
            r_rv      <= n_rv;
            r_found   <= n_found;
            r_m_valid <= n_m_valid;
        end
        r_op        <= n_op;
        r_id        <= n_id;
        r_new       <= n_new;
        r_carry     <= n_carry;
        r_ri        <= n_ri;
        r_hit       <= n_hit;
        r_status    <= n_status;
        r_best_prio <= n_best_prio;
        r_best_id   <= n_best_id;
        r_m_data    <= n_m_data;
    end

`ifndef NO_ASSERTIONS
    // an accepted operation always starts work
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state != S_IDLE))
        else $error("accepted operation left the sequencer idle");

    // the tail slot is only written when the table has room
    a_tail_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAIL) |-> (r_count < hrq_pkg::CNT_W'(hrq_pkg::DEPTH)))
        else $error("tail write into a full table");

    // job count moves by at most one per cycle
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == $past(r_count)) || (r_count == $past(r_count) + 1'b1) ||
        (r_count == $past(r_count) - 1'b1))
        else $error("job count jumped");

    // divider runs and reports only while a tick waits for it
    a_div_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (div_rsp.busy || div_rsp.done) |-> (r_state == S_DIV))
        else $error("divider active outside tick");
`endif

endmodule

// ===== bench/hrq_monitor.sv =====
// Transfer monitor for the HRRN ready queue: predicts each result and compares it.
// Depends on hrq_pkg; instantiated by the testbench top beside the core.
`timescale 1ns / 1ps

module hrq_monitor
    import hrq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic [OP_W-1:0]       i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    output int                    o_fail_count,
    output int                    o_pending
);

    // same layout as the output tdata, status in the top bits
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  job_count;
        logic                pick_valid;
        logic [ID_W-1:0]     pick_id;
    } t_report;

    logic [ID_W-1:0]   tbl_job  [DEPTH];
    logic [TIME_W-1:0] tbl_wait [DEPTH];
    logic [TIME_W-1:0] tbl_est  [DEPTH];
    logic [PRIO_W-1:0] tbl_prio [DEPTH];
    int                held;

    t_report due_reports[$];
    t_report got;
    t_report want;
    int      n_in = 0;
    int      n_out = 0;
    int      errs = 0;

    assign o_fail_count = errs;
    assign o_pending    = n_in - n_out;

    function automatic logic [PRIO_W-1:0] ratio_prio(input logic [TIME_W-1:0] waited,
                                                     input logic [TIME_W-1:0] est);
        logic [63:0] q;
        if (est == '0)
            return PRIO_MAX;
        q = {40'd0, waited, 8'd0} / (64'(est) * 64'd10) + 64'd256;
        return (q > 64'(PRIO_MAX)) ? PRIO_MAX : q[PRIO_W-1:0];
    endfunction

    function automatic int find_job(input logic [ID_W-1:0] id);
        for (int i = 0; i < held; i++)
            if (tbl_job[i] == id)
                return i;
        return -1;
    endfunction

    // updates the table copy and returns the report for one operation
    function automatic t_report apply_op(input logic [OP_W-1:0]   op,
                                         input logic [ID_W-1:0]   id,
                                         input logic [TIME_W-1:0] est,
                                         input logic [TIME_W-1:0] waited,
                                         input logic [PRIO_W-1:0] prio);
        t_report r;
        int      pos;
        int      hit;
        int      best;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_ENQUEUE: begin
                if (held >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // before the first entry of strictly lower priority
                    pos = held;
                    for (int i = held - 1; i >= 0; i--)
                        if (prio > tbl_prio[i])
                            pos = i;
                    for (int i = held; i > pos; i--) begin
                        tbl_job[i]  = tbl_job[i-1];
                        tbl_wait[i] = tbl_wait[i-1];
                        tbl_est[i]  = tbl_est[i-1];
                        tbl_prio[i] = tbl_prio[i-1];
                    end
                    tbl_job[pos]  = id;
                    tbl_wait[pos] = waited;
                    tbl_est[pos]  = est;
                    tbl_prio[pos] = prio;
                    held++;
                end
            end
            OP_DEQUEUE: begin
                hit = find_job(id);
                if (hit < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    for (int i = hit; i + 1 < held; i++) begin
                        tbl_job[i]  = tbl_job[i+1];
                        tbl_wait[i] = tbl_wait[i+1];
                        tbl_est[i]  = tbl_est[i+1];
                        tbl_prio[i] = tbl_prio[i+1];
                    end
                    held--;
                end
            end
            OP_TICK: begin
                hit = find_job(id);
                if (hit < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    if (tbl_wait[hit] != '1)
                        tbl_wait[hit] = tbl_wait[hit] + 1'b1;
                    tbl_prio[hit] = ratio_prio(tbl_wait[hit], tbl_est[hit]);
                end
            end
            default: ;
        endcase
        if (held > 0) begin
            best = 0;
            for (int i = 1; i < held; i++)
                if (tbl_prio[i] > tbl_prio[best])
                    best = i;
            r.pick_id    = tbl_job[best];
            r.pick_valid = 1'b1;
        end
        r.job_count = COUNT_W'(held);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held = 0;
            due_reports.delete();
        end else begin
            // output side first: a result never belongs to the op accepted this edge
            if (i_m_tvalid && i_m_tready) begin
                got = t_report'(i_m_tdata);
                n_out <= n_out + 1;
                if (due_reports.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("%0t: result with nothing outstanding: id %0d v %0d cnt %0d st %0d",
                                 $realtime, got.pick_id, got.pick_valid, got.job_count,
                                 got.status);
                end else begin
                    want = due_reports.pop_front();
                    if (got.pick_id !== want.pick_id || got.pick_valid !== want.pick_valid ||
                        got.job_count !== want.job_count || got.status !== want.status) begin
                        errs++;
                        if (errs <= 10)
                            $display("%0t: mismatch exp id %0d v %0d cnt %0d st %0d, got id %0d v %0d cnt %0d st %0d",
                                     $realtime, want.pick_id, want.pick_valid, want.job_count,
                                     want.status, got.pick_id, got.pick_valid, got.job_count,
                                     got.status);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                due_reports.push_back(apply_op(i_s_tuser,
                                               i_s_tdata[ID_W-1:0],
                                               i_s_tdata[EST_LSB +: TIME_W],
                                               i_s_tdata[WAIT_LSB +: TIME_W],
                                               i_s_tdata[PRIO_LSB +: PRIO_W]));
                n_in <= n_in + 1;
            end
        end
    end

endmodule

// ===== bench/testbench.sv =====
// Top of the HRRN ready queue bench: clock, reset, operation stimulus and verdict.
// Depends on hrq_pkg, hrrn_ready_queue_core and hrq_monitor.
`timescale 1ns / 1ps

module testbench;
    import hrq_pkg::*;

    logic                  i_clk;
    logic                  rst_n   = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [IN_DATA_W-1:0]  s_data  = '0;
    logic [OP_W-1:0]       s_user  = OP_PICK;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [OUT_DATA_W-1:0] m_data;

    int fail_count;
    int pending;

    // idle odds in percent, per phase
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    // one long receiver hold-off, owned by the receiver process
    logic hold_go   = 1'b0;
    logic hold_used = 1'b0;
    int   hold_left = 0;

    hrrn_ready_queue_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    hrq_monitor u_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_valid),
        .i_s_tready   (s_ready),
        .i_s_tdata    (s_data),
        .i_s_tuser    (s_user),
        .i_m_tvalid   (m_valid),
        .i_m_tready   (m_ready),
        .i_m_tdata    (m_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Receiver: random stalls at the phase rate, plus one unbroken hold-off
    // so the output register and sequencer back up and tready drops.
    always @(posedge i_clk) begin
        if (hold_go && !hold_used) begin
            hold_used <= 1'b1;
            hold_left <= 400;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Offer one operation and hold it until the transfer. Gaps come first,
    // so valid is only ever assigned once per edge.
    task automatic push_op(input logic [OP_W-1:0]   op,
                           input logic [ID_W-1:0]   id,
                           input logic [TIME_W-1:0] est,
                           input logic [TIME_W-1:0] waited,
                           input logic [PRIO_W-1:0] prio);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= op;
        s_data  <= {3'b000, prio, waited, est, id};
        do @(posedge i_clk); while (!s_ready);
    endtask

    // Sender quiet until every outstanding result has come back.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    // Random op. Fill mode leans on enqueue, drain mode on dequeue, so the
    // count swings between empty and full. Ids mostly from a small pool so
    // dequeue and tick usually hit, the rest mostly miss.
    task automatic random_op(input bit filling);
        logic [OP_W-1:0]   op;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] est;
        logic [TIME_W-1:0] waited;
        logic [PRIO_W-1:0] prio;
        int                r;
        r = $urandom_range(99);
        if (filling)
            op = (r < 50) ? OP_ENQUEUE : (r < 65) ? OP_DEQUEUE : (r < 92) ? OP_TICK : OP_PICK;
        else
            op = (r < 15) ? OP_ENQUEUE : (r < 55) ? OP_DEQUEUE : (r < 90) ? OP_TICK : OP_PICK;
        id = ($urandom_range(99) < 85) ? ID_W'($urandom_range(19)) : ID_W'($urandom());
        r = $urandom_range(9);
        if (r == 0)
            est = '0;
        else if (r < 5)
            est = TIME_W'($urandom_range(20, 1));
        else if (r < 8)
            est = TIME_W'($urandom_range(1000, 1));
        else
            est = TIME_W'($urandom());
        r = $urandom_range(9);
        if (r < 5)
            waited = TIME_W'($urandom_range(100));
        else if (r < 7)
            waited = TIME_W'($urandom_range(65535, 65530));
        else
            waited = TIME_W'($urandom());
        // narrow band near 1.0 gives plenty of ties
        r = $urandom_range(9);
        if (r < 4)
            prio = PRIO_W'($urandom_range(259, 256));
        else if (r < 7)
            prio = PRIO_W'($urandom_range(4096));
        else
            prio = PRIO_W'($urandom());
        push_op(op, id, est, waited, prio);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty-table cases
        push_op(OP_PICK,    8'd0, 16'd0, 16'd0, '0);
        push_op(OP_DEQUEUE, 8'd7, 16'd0, 16'd0, '0);
        push_op(OP_TICK,    8'd7, 16'd0, 16'd0, '0);
        // field extremes, duplicate id with a tied priority
        push_op(OP_ENQUEUE, 8'd0,   16'd0,     16'd0,     '0);
        push_op(OP_ENQUEUE, 8'd255, 16'hFFFF,  16'hFFFF,  PRIO_MAX);
        push_op(OP_ENQUEUE, 8'd7,   16'd1,     16'hFFFF,  PRIO_W'(PRIO_ONE));
        push_op(OP_ENQUEUE, 8'd7,   16'd3,     16'd10,    PRIO_W'(PRIO_ONE));
        // zero estimate saturates priority; tie keeps table order for the pick
        push_op(OP_TICK,    8'd0,   16'd0,     16'd0,     '0);
        // first id-7 entry: waiting time already at its ceiling
        push_op(OP_TICK,    8'd7,   16'd0,     16'd0,     '0);
        // fill to sixteen, then one more is dropped
        for (int k = 0; k < 12; k++)
            push_op(OP_ENQUEUE, ID_W'(10 + k), TIME_W'(k + 1), TIME_W'(k * 7),
                    PRIO_W'((k % 3) * 300 + 256));
        push_op(OP_ENQUEUE, 8'd99,  16'd5,     16'd5,     PRIO_W'(PRIO_ONE));
        push_op(OP_DEQUEUE, 8'd7,   16'd0,     16'd0,     '0);
        push_op(OP_PICK,    8'd0,   16'd0,     16'd0,     '0);
        push_op(OP_DEQUEUE, 8'd255, 16'd0,     16'd0,     '0);

        // random phases: no idling, sender idle, receiver stalls, both light
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct <= 0;  end
                1: begin src_idle_pct = 55; sink_stall_pct <= 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct <= 55; end
                default: begin src_idle_pct = 7; sink_stall_pct <= 7; end
            endcase
            for (int n = 0; n < 125; n++) begin
                // long hold-off while the sender keeps pushing
                if (ph == 0 && n == 30)
                    hold_go <= 1'b1;
                random_op(((n / 40) % 2) == 0);
            end
            if (ph == 1)
                wait_for_results();
        end

        // drain, then allow for an op still in flight
        src_idle_pct = 0;
        sink_stall_pct <= 0;
        wait_for_results();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
